/* design/mccs_pkg.sv */
// Shared constants and result kind codes for the minimum-dart solver.
package mccs_pkg;

  localparam int MAX_SECTORS = 32;
  localparam int MAX_TARGET  = 16383;

  localparam int VAL_W  = 14;
  localparam int KIND_W = 2;
  localparam int SIDX_W = $clog2(MAX_SECTORS);
  localparam int SCNT_W = $clog2(MAX_SECTORS + 1);
  localparam int TBL_DEPTH = MAX_TARGET + 1;
  localparam int TBL_AW = $clog2(TBL_DEPTH);
  localparam int CNT_W  = 15;

  localparam logic [CNT_W-1:0] INF_COUNT = {CNT_W{1'b1}};

  localparam logic [KIND_W-1:0] KIND_HEADER     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_IMPOSSIBLE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RUN        = 2'd2;

endpackage

/* design/min_coin_change_solver.sv */
// Minimum-dart solver: sector store, count table in memory, relaxation and walk-back control.
//
// Sector values are loaded one per transaction, one every clock cycle, while busy is low.
// The transaction that carries last_sector raises busy until the final result has been
// presented. The solve first clears the count table for scores 0..target_score (one entry
// a cycle), then runs one pass per usable sector that updates one table entry per cycle,
// then walks back through the table from the last sector. The table memory has a single
// write port and a registered read. Results appear for one cycle each with result_valid
// and cannot be held off; a new case can be loaded as soon as busy falls.
module min_coin_change_solver (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [mccs_pkg::VAL_W-1:0]      sector_value,
  input  logic                            last_sector,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mccs_pkg::VAL_W-1:0]      cfg_data,
  output logic                            result_valid,
  output logic [mccs_pkg::KIND_W-1:0]     kind,
  output logic [mccs_pkg::VAL_W-1:0]      value,
  output logic [mccs_pkg::VAL_W-1:0]      repeat_res,
  output logic                            overflow,
  output logic                            last
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_SREQ = 4'd2;
  localparam logic [3:0] S_SGET = 4'd3;
  localparam logic [3:0] S_DP   = 4'd4;
  localparam logic [3:0] S_WCHK = 4'd5;
  localparam logic [3:0] S_WS   = 4'd6;
  localparam logic [3:0] S_WT   = 4'd7;
  localparam logic [3:0] S_WD   = 4'd8;

  logic [3:0] state;
  logic [mccs_pkg::VAL_W-1:0]  target;
  logic [mccs_pkg::SCNT_W-1:0] scount;
  logic                        dropped;
  logic [mccs_pkg::SCNT_W-1:0] si;
  logic [mccs_pkg::SCNT_W-1:0] idx;
  logic [mccs_pkg::TBL_AW-1:0] cj;
  logic [mccs_pkg::TBL_AW-1:0] j;
  logic [mccs_pkg::VAL_W-1:0]  dv;
  logic                        issue_on;
  logic                        p_valid;
  logic [mccs_pkg::TBL_AW-1:0] p_addr;
  logic [mccs_pkg::VAL_W-1:0]  rem;
  logic [mccs_pkg::VAL_W-1:0]  run_val;
  logic [mccs_pkg::VAL_W-1:0]  run_len;
  logic [mccs_pkg::VAL_W-1:0]  mincnt;

  logic [mccs_pkg::VAL_W-1:0]  smem [mccs_pkg::MAX_SECTORS];
  logic [mccs_pkg::VAL_W-1:0]  srd;
  logic [mccs_pkg::SIDX_W-1:0] sa;
  logic                        store_we;

  logic [mccs_pkg::CNT_W-1:0]  tmem [mccs_pkg::TBL_DEPTH];
  logic [mccs_pkg::CNT_W-1:0]  rda;
  logic [mccs_pkg::CNT_W-1:0]  rdb;
  logic [mccs_pkg::TBL_AW-1:0] tbl_ra;
  logic [mccs_pkg::TBL_AW-1:0] tbl_rb;
  logic                        tbl_we;
  logic [mccs_pkg::TBL_AW-1:0] tbl_wa;
  logic [mccs_pkg::CNT_W-1:0]  tbl_wd;
  logic                        fwd_a;
  logic                        fwd_b;
  logic [mccs_pkg::CNT_W-1:0]  fwd_data;
  logic [mccs_pkg::CNT_W-1:0]  rda_eff;
  logic [mccs_pkg::CNT_W-1:0]  rdb_eff;
  logic [mccs_pkg::CNT_W-1:0]  a_inc;
  logic                        in_acc;
  logic                        take;
  logic [mccs_pkg::SCNT_W-1:0] idx_m1;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = !busy;
  assign in_acc    = start && !busy;
  assign store_we  = in_acc && (scount < mccs_pkg::SCNT_W'(mccs_pkg::MAX_SECTORS));
  assign rda_eff   = fwd_a ? fwd_data : rda;
  assign rdb_eff   = fwd_b ? fwd_data : rdb;
  assign a_inc     = rda_eff + mccs_pkg::CNT_W'(1);
  assign idx_m1    = idx - mccs_pkg::SCNT_W'(1);
  assign take      = (dv != '0) && (dv <= rem) && (rda_eff != mccs_pkg::INF_COUNT) &&
                     (rdb_eff == a_inc);

  always_comb begin
    sa     = '0;
    tbl_ra = '0;
    tbl_rb = '0;
    tbl_we = 1'b0;
    tbl_wa = '0;
    tbl_wd = '0;
    case (state)
      S_CLR: begin
        tbl_we = 1'b1;
        tbl_wa = cj;
        tbl_wd = (cj == '0) ? '0 : mccs_pkg::INF_COUNT;
      end
      S_SREQ: begin
        sa     = si[mccs_pkg::SIDX_W-1:0];
        tbl_rb = mccs_pkg::TBL_AW'(target);
      end
      S_DP: begin
        tbl_ra = j - mccs_pkg::TBL_AW'(dv);
        tbl_rb = j;
        tbl_we = p_valid;
        tbl_wa = p_addr;
        if ((rda_eff != mccs_pkg::INF_COUNT) && (a_inc < rdb_eff)) begin
          tbl_wd = a_inc;
        end else begin
          tbl_wd = rdb_eff;
        end
      end
      S_WS: begin
        sa = idx_m1[mccs_pkg::SIDX_W-1:0];
      end
      S_WT: begin
        tbl_ra = mccs_pkg::TBL_AW'(rem - srd);
        tbl_rb = mccs_pkg::TBL_AW'(rem);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      smem[scount[mccs_pkg::SIDX_W-1:0]] <= sector_value;
    end
    srd <= smem[sa];
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tmem[tbl_wa] <= tbl_wd;
    end
    rda      <= tmem[tbl_ra];
    rdb      <= tmem[tbl_rb];
    fwd_a    <= tbl_we && (tbl_ra == tbl_wa);
    fwd_b    <= tbl_we && (tbl_rb == tbl_wa);
    fwd_data <= tbl_wd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      target       <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      scount       <= '0;
      dropped      <= 1'b0;
      result_valid <= 1'b0;
      issue_on     <= 1'b0;
      p_valid      <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (store_we) begin
              scount <= scount + mccs_pkg::SCNT_W'(1);
            end else begin
              dropped <= 1'b1;
            end
            if (last_sector) begin
              cj    <= '0;
              state <= S_CLR;
            end
          end
        end
        S_CLR: begin
          if (cj == mccs_pkg::TBL_AW'(target)) begin
            si    <= '0;
            state <= S_SREQ;
          end else begin
            cj <= cj + mccs_pkg::TBL_AW'(1);
          end
        end
        S_SREQ: begin
          if (si == scount) begin
            state <= S_WCHK;
          end else begin
            state <= S_SGET;
          end
        end
        S_SGET: begin
          if ((srd == '0) || (srd > target)) begin
            si    <= si + mccs_pkg::SCNT_W'(1);
            state <= S_SREQ;
          end else begin
            dv       <= srd;
            j        <= mccs_pkg::TBL_AW'(srd);
            issue_on <= 1'b1;
            p_valid  <= 1'b0;
            state    <= S_DP;
          end
        end
        S_DP: begin
          p_valid <= issue_on;
          p_addr  <= j;
          if (issue_on) begin
            if (j == mccs_pkg::TBL_AW'(target)) begin
              issue_on <= 1'b0;
            end else begin
              j <= j + mccs_pkg::TBL_AW'(1);
            end
          end else if (!p_valid) begin
            si    <= si + mccs_pkg::SCNT_W'(1);
            state <= S_SREQ;
          end
        end
        S_WCHK: begin
          if (rdb_eff == mccs_pkg::INF_COUNT) begin
            result_valid <= 1'b1;
            kind         <= mccs_pkg::KIND_IMPOSSIBLE;
            value        <= '0;
            repeat_res   <= '0;
            overflow     <= dropped;
            last         <= 1'b1;
            scount       <= '0;
            dropped      <= 1'b0;
            state        <= S_IDLE;
          end else begin
            mincnt  <= rdb_eff[mccs_pkg::VAL_W-1:0];
            rem     <= target;
            idx     <= scount;
            run_len <= '0;
            state   <= S_WS;
          end
        end
        S_WS: begin
          if ((rem == '0) || (idx == '0)) begin
            result_valid <= 1'b1;
            overflow     <= dropped;
            last         <= 1'b1;
            if (run_len != '0) begin
              kind       <= mccs_pkg::KIND_RUN;
              value      <= run_val;
              repeat_res <= run_len;
            end else begin
              kind       <= mccs_pkg::KIND_HEADER;
              value      <= mincnt;
              repeat_res <= '0;
            end
            scount  <= '0;
            dropped <= 1'b0;
            state   <= S_IDLE;
          end else begin
            state <= S_WT;
          end
        end
        S_WT: begin
          dv    <= srd;
          state <= S_WD;
        end
        S_WD: begin
          if (take) begin
            if (run_len == '0) begin
              result_valid <= 1'b1;
              kind         <= mccs_pkg::KIND_HEADER;
              value        <= mincnt;
              repeat_res   <= '0;
              overflow     <= dropped;
              last         <= 1'b0;
              run_len      <= mccs_pkg::VAL_W'(1);
            end else if (run_val != dv) begin
              result_valid <= 1'b1;
              kind         <= mccs_pkg::KIND_RUN;
              value        <= run_val;
              repeat_res   <= run_len;
              overflow     <= dropped;
              last         <= 1'b0;
              run_len      <= mccs_pkg::VAL_W'(1);
            end else begin
              run_len <= run_len + mccs_pkg::VAL_W'(1);
            end
            run_val <= dv;
            rem     <= rem - dv;
          end else begin
            idx <= idx_m1;
          end
          state <= S_WS;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_impossible_alone: assert property (@(posedge clk) disable iff (rst)
    result_valid && (kind == mccs_pkg::KIND_IMPOSSIBLE) |-> last && (value == '0))
    else $error("impossible result is not a lone final transaction");

  a_last_ends_case: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |-> (state == S_IDLE) && (scount == '0) && !dropped)
    else $error("case state not released with the final result");

  a_no_result_while_loading: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) && $past(state == S_IDLE) |-> !result_valid)
    else $error("result presented without a solve in progress");

  a_dp_write_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DP) && p_valid |-> (p_addr <= mccs_pkg::TBL_AW'(target)))
    else $error("table update beyond the target score");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    scount <= mccs_pkg::SCNT_W'(mccs_pkg::MAX_SECTORS))
    else $error("sector count exceeds store capacity");
`endif

endmodule

/* verif/tb.sv */
// Self-checking testbench for the minimum-dart solver: directed table, then random cases.
`timescale 1ns / 100ps

module tb;

  localparam int SETTLE   = 8;
  localparam int TAIL     = 20;
  localparam int WATCHDOG = 400000;
  localparam int RAND_LOADS = 315;
  localparam int NDIR     = 18;

  typedef struct packed {
    logic [mccs_pkg::KIND_W-1:0] kind;
    logic [mccs_pkg::VAL_W-1:0]  value;
    logic [mccs_pkg::VAL_W-1:0]  reps;
    logic                        ovf;
    logic                        fin;
  } dart_res_t;

  typedef struct packed {
    logic                        set_tgt;
    logic [mccs_pkg::VAL_W-1:0]  tgt;
    logic [mccs_pkg::VAL_W-1:0]  sector;
    logic                        fin;
    logic                        typed;
    logic [mccs_pkg::KIND_W-1:0] t_kind;
    logic [mccs_pkg::VAL_W-1:0]  t_value;
  } dir_row_t;

  logic                        clk;
  logic                        rst;
  logic                        start;
  logic                        busy;
  logic [mccs_pkg::VAL_W-1:0]  sector_value;
  logic                        last_sector;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [mccs_pkg::VAL_W-1:0]  cfg_data;
  logic                        result_valid;
  logic [mccs_pkg::KIND_W-1:0] kind;
  logic [mccs_pkg::VAL_W-1:0]  value;
  logic [mccs_pkg::VAL_W-1:0]  repeat_res;
  logic                        overflow;
  logic                        last;

  // Predictor state.
  logic [mccs_pkg::VAL_W-1:0] loaded_sectors [0:mccs_pkg::MAX_SECTORS-1];
  int                         loaded_cnt = 0;
  logic                       sectors_dropped = 1'b0;
  logic [mccs_pkg::VAL_W-1:0] target_reg = '0;
  logic [mccs_pkg::CNT_W-1:0] min_darts [0:mccs_pkg::MAX_TARGET];
  dart_res_t                  dart_plan_q [$];

  // Expectation typed in by the directed table for the case that ends now.
  logic             typed_on = 1'b0;
  dart_res_t        typed_res;

  logic [mccs_pkg::VAL_W-1:0] drv_target = '0;
  dart_res_t        got;
  dart_res_t        want;
  logic             progress;
  int               quiet_cycles = 0;
  int               errors = 0;
  int               loads_seen = 0;
  int               cases_seen = 0;
  int               drop_cases = 0;
  int               results_seen = 0;
  int               cfg_writes = 0;
  int               rand_loads = 0;

  dir_row_t dir_tab [NDIR] = '{
    '{1'b0, 14'd0,     14'd5,     1'b1, 1'b1, mccs_pkg::KIND_HEADER,     14'd0},
    '{1'b1, 14'd7,     14'd0,     1'b1, 1'b1, mccs_pkg::KIND_IMPOSSIBLE, 14'd0},
    '{1'b1, 14'd7,     14'd2,     1'b0, 1'b0, mccs_pkg::KIND_HEADER,     14'd0},
    '{1'b0, 14'd0,     14'd4,     1'b1, 1'b1, mccs_pkg::KIND_IMPOSSIBLE, 14'd0},
    '{1'b1, 14'd16383, 14'd16383, 1'b1, 1'b0, mccs_pkg::KIND_HEADER,     14'd0},
    '{1'b0, 14'd0,     14'd1,     1'b0, 1'b0, mccs_pkg::KIND_HEADER,     14'd0},
    '{1'b0, 14'd0,     14'd8192,  1'b1, 1'b0, mccs_pkg::KIND_HEADER,     14'd0},
    '{1'b1, 14'd10,    14'd3,     1'b0, 1'b0, mccs_pkg::KIND_HEADER,     14'd0},
    '{1'b0, 14'd0,     14'd3,     1'b0, 1'b0, mccs_pkg::KIND_HEADER,     14'd0},
    '{1'b0, 14'd0,     14'd4,     1'b1, 1'b0, mccs_pkg::KIND_HEADER,     14'd0},
    '{1'b1, 14'd5,     14'd9,     1'b0, 1'b0, mccs_pkg::KIND_HEADER,     14'd0},
    '{1'b0, 14'd0,     14'd0,     1'b0, 1'b0, mccs_pkg::KIND_HEADER,     14'd0},
    '{1'b0, 14'd0,     14'd5,     1'b1, 1'b0, mccs_pkg::KIND_HEADER,     14'd0},
    '{1'b1, 14'd1,     14'd1,     1'b1, 1'b0, mccs_pkg::KIND_HEADER,     14'd0},
    '{1'b1, 14'd0,     14'd16383, 1'b1, 1'b1, mccs_pkg::KIND_HEADER,     14'd0},
    '{1'b1, 14'd12,    14'd6,     1'b0, 1'b0, mccs_pkg::KIND_HEADER,     14'd0},
    '{1'b0, 14'd0,     14'd1,     1'b0, 1'b0, mccs_pkg::KIND_HEADER,     14'd0},
    '{1'b0, 14'd0,     14'd4,     1'b1, 1'b0, mccs_pkg::KIND_HEADER,     14'd0}
  };

  min_coin_change_solver u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .sector_value (sector_value),
    .last_sector  (last_sector),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .kind         (kind),
    .value        (value),
    .repeat_res   (repeat_res),
    .overflow     (overflow),
    .last         (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Fills the count table for the current target, then walks back from the last sector.
  task automatic plan_darts();
    int t, i, j, d, prev, idx, rem, run_val, run_len;
    dart_res_t r;
    dart_res_t plan [$];
    t = int'(target_reg);
    r.ovf = sectors_dropped;
    r.reps = '0;
    r.fin = 1'b0;
    r.value = '0;
    min_darts[0] = '0;
    for (j = 1; j <= t; j++) min_darts[j] = mccs_pkg::INF_COUNT;
    for (i = 0; i < loaded_cnt; i++) begin
      d = int'(loaded_sectors[i]);
      if (d != 0 && d <= t) begin
        for (j = d; j <= t; j++) begin
          prev = int'(min_darts[j-d]);
          if (prev != mccs_pkg::INF_COUNT && prev + 1 < min_darts[j]) begin
            min_darts[j] = mccs_pkg::CNT_W'(prev + 1);
          end
        end
      end
    end
    if (min_darts[t] == mccs_pkg::INF_COUNT) begin
      r.kind = mccs_pkg::KIND_IMPOSSIBLE;
      plan.push_back(r);
    end else begin
      r.kind = mccs_pkg::KIND_HEADER;
      r.value = min_darts[t][mccs_pkg::VAL_W-1:0];
      plan.push_back(r);
      r.kind = mccs_pkg::KIND_RUN;
      idx = loaded_cnt;
      rem = t;
      run_val = 0;
      run_len = 0;
      while (rem > 0 && idx > 0) begin
        d = int'(loaded_sectors[idx-1]);
        if (d != 0 && d <= rem && min_darts[rem-d] != mccs_pkg::INF_COUNT &&
            min_darts[rem] == min_darts[rem-d] + 1) begin
          if (run_len > 0 && run_val != d) begin
            r.value = mccs_pkg::VAL_W'(run_val);
            r.reps = mccs_pkg::VAL_W'(run_len);
            plan.push_back(r);
            run_len = 0;
          end
          run_val = d;
          run_len++;
          rem -= d;
        end else begin
          idx--;
        end
      end
      if (run_len > 0) begin
        r.value = mccs_pkg::VAL_W'(run_val);
        r.reps = mccs_pkg::VAL_W'(run_len);
        plan.push_back(r);
      end
    end
    r = plan.pop_back();
    r.fin = 1'b1;
    plan.push_back(r);
    for (i = 0; i < plan.size(); i++) dart_plan_q.push_back(plan[i]);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      progress = 1'b0;
      if (cfg_valid && cfg_ready) begin
        target_reg = cfg_data;
        cfg_writes++;
        progress = 1'b1;
      end
      if (start && !busy) begin
        if (loaded_cnt < mccs_pkg::MAX_SECTORS) begin
          loaded_sectors[loaded_cnt] = sector_value;
          loaded_cnt++;
        end else begin
          sectors_dropped = 1'b1;
        end
        loads_seen++;
        progress = 1'b1;
        if (last_sector) begin
          if (typed_on) dart_plan_q.push_back(typed_res);
          else plan_darts();
          if (sectors_dropped) drop_cases++;
          cases_seen++;
          loaded_cnt = 0;
          sectors_dropped = 1'b0;
        end
      end
      if (result_valid) begin
        got = '{kind, value, repeat_res, overflow, last};
        results_seen++;
        progress = 1'b1;
        if (dart_plan_q.size() == 0) begin
          $display("%0t: unexpected result kind=%0d value=%0d repeat=%0d overflow=%0b last=%0b",
                   $time, got.kind, got.value, got.reps, got.ovf, got.fin);
          errors++;
        end else begin
          want = dart_plan_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected kind=%0d value=%0d repeat=%0d overflow=%0b last=%0b",
                     $time, want.kind, want.value, want.reps, want.ovf, want.fin);
            $display("%0t:          actual   kind=%0d value=%0d repeat=%0d overflow=%0b last=%0b",
                     $time, got.kind, got.value, got.reps, got.ovf, got.fin);
            errors++;
          end
        end
      end
      if (progress) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG) begin
          $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                   $time, WATCHDOG, dart_plan_q.size());
          $display("*** FAILED ***");
          $finish;
        end
      end
    end
  end

  task automatic send_item(input logic [mccs_pkg::VAL_W-1:0] v, input logic fin);
    start <= 1'b1;
    sector_value <= v;
    last_sector <= fin;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic hold_off(input int n);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic write_target(input logic [mccs_pkg::VAL_W-1:0] t);
    start <= 1'b0;
    while (dart_plan_q.size() != 0 || busy) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= t;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    drv_target = t;
  endtask

  function automatic logic [mccs_pkg::VAL_W-1:0] pick_sector(input int tgt);
    int p;
    p = $urandom_range(0, 99);
    if (p < 8) return '0;
    if (p < 18) return mccs_pkg::VAL_W'($urandom_range(0, mccs_pkg::MAX_TARGET));
    if (p < 26 && tgt < mccs_pkg::MAX_TARGET) begin
      return mccs_pkg::VAL_W'($urandom_range(tgt + 1, mccs_pkg::MAX_TARGET));
    end
    if (tgt < 2) return mccs_pkg::VAL_W'($urandom_range(1, 3));
    if (p < 60) return mccs_pkg::VAL_W'($urandom_range(1, tgt / 3 + 1));
    return mccs_pkg::VAL_W'($urandom_range(1, tgt));
  endfunction

  task automatic random_case(input int idle_pct, input bit new_target);
    int n, k, r;
    logic [mccs_pkg::VAL_W-1:0] t;
    if (new_target || $urandom_range(0, 99) < 60) begin
      r = $urandom_range(0, 99);
      if (r < 2) t = mccs_pkg::VAL_W'(mccs_pkg::MAX_TARGET);
      else if (r < 5) t = mccs_pkg::VAL_W'($urandom_range(4096, mccs_pkg::MAX_TARGET));
      else if (r < 10) t = '0;
      else if (r < 70) t = mccs_pkg::VAL_W'($urandom_range(1, 40));
      else t = mccs_pkg::VAL_W'($urandom_range(41, 400));
      write_target(t);
    end
    r = $urandom_range(0, 99);
    if (drv_target > 400) n = $urandom_range(1, 3);
    else if (r < 75) n = $urandom_range(1, 8);
    else if (r < 90) n = $urandom_range(9, mccs_pkg::MAX_SECTORS);
    else n = $urandom_range(mccs_pkg::MAX_SECTORS + 1, mccs_pkg::MAX_SECTORS + 8);
    typed_on = 1'b0;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < idle_pct) hold_off($urandom_range(1, 4));
      send_item(pick_sector(int'(drv_target)), k == n - 1);
      rand_loads++;
    end
  endtask

  initial begin
    int k, phase, prev_phase, idle_pct;
    dir_row_t row;
    rst = 1'b1;
    start = 1'b0;
    sector_value = '0;
    last_sector = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (k = 0; k < NDIR; k++) begin
      row = dir_tab[k];
      if (row.set_tgt) write_target(row.tgt);
      typed_on = row.typed;
      typed_res = '{row.t_kind, row.t_value, {mccs_pkg::VAL_W{1'b0}}, 1'b0, 1'b1};
      send_item(row.sector, row.fin);
    end

    // Sender idling by phase; the result side cannot be stalled.
    prev_phase = -1;
    while (rand_loads < RAND_LOADS) begin
      phase = rand_loads * 4 / RAND_LOADS;
      idle_pct = (phase == 1) ? 47 : (phase == 3) ? 28 : 0;
      random_case(idle_pct, phase != prev_phase);
      prev_phase = phase;
    end

    start <= 1'b0;
    while (dart_plan_q.size() != 0 || busy) @(negedge clk);
    repeat (TAIL) @(negedge clk);
    $display("Covered %0d cases from %0d sector loads, %0d of them past the store limit.",
             cases_seen, loads_seen, drop_cases);
    $display("Checked %0d results over %0d target writes; %0d errors.",
             results_seen, cfg_writes, errors);
    if (errors == 0 && dart_plan_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
